[src/aabb_matrix_transform_macros.svh]
// Assertion macros for the box transform block.
// Included by the top level only; no other dependencies.
`ifndef AABB_MATRIX_TRANSFORM_MACROS_SVH
`define AABB_MATRIX_TRANSFORM_MACROS_SVH

// Same-cycle implication, disabled in reset
`define AMT_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("amt assertion failed");

// Next-cycle implication, disabled in reset
`define AMT_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("amt assertion failed");

`endif

[src/amt_pkg.sv]
// Shared types and constants for the box transform block.
// No dependencies; used by every module of the block.
`default_nettype none

package amt_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int COORD_W       = 32;
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int PROD_W        = 64;
  localparam int SUM_W         = 67;
  localparam int MAG_W         = 66;
  localparam int QUO_W         = 32;
  localparam int NUM_AXES      = 3;
  localparam int CORNERS       = 8;

  localparam logic [COORD_W-1:0] POS_LIM = 32'h7FFF_FFFF;
  localparam logic [COORD_W-1:0] NEG_LIM = 32'h8000_0000;

  // Register index codes
  localparam logic [CFG_IDX_W-1:0] REG_ROW0_LEFT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1_LEFT  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2_RIGHT = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ROW3_RIGHT = 4'd7;

  typedef struct packed {
    logic signed [COORD_W-1:0] in_min_x;
    logic signed [COORD_W-1:0] in_min_y;
    logic signed [COORD_W-1:0] in_min_z;
    logic signed [COORD_W-1:0] in_max_x;
    logic signed [COORD_W-1:0] in_max_y;
    logic signed [COORD_W-1:0] in_max_z;
  } box_in_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_min_x;
    logic signed [COORD_W-1:0] out_min_y;
    logic signed [COORD_W-1:0] out_min_z;
    logic signed [COORD_W-1:0] out_max_x;
    logic signed [COORD_W-1:0] out_max_y;
    logic signed [COORD_W-1:0] out_max_z;
    logic                      box_valid;
    logic                      overflow;
  } box_out_t;

  // Matrix entries, indexed [row][col]
  typedef logic [3:0][3:0][COORD_W-1:0] matrix_t;

  // Per-corner control traveling with the data
  typedef struct packed {
    logic first;
    logic last;
    logic bad;
    logic ws;
    logic wzero;
  } meta_t;

  // Per-axis sign and special-case flags
  typedef struct packed {
    logic ns;
    logic nzero;
    logic pre;
  } lane_t;

  // Reset contents of the matrix registers (identity)
  function automatic logic [CFG_DATA_W-1:0] reg_reset(input logic [CFG_IDX_W-1:0] idx);
    logic [CFG_DATA_W-1:0] v;
    v = '0;
    case (idx)
      REG_ROW0_LEFT, REG_ROW2_RIGHT: v = 64'h0000_0000_0001_0000;
      REG_ROW1_LEFT, REG_ROW3_RIGHT: v = 64'h0001_0000_0000_0000;
      default:                       v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[src/amt_corner.sv]
// Corner sequencer: latches a box request and issues its eight corners.
// Depends on amt_pkg.
`default_nettype none

module amt_corner (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire amt_pkg::box_in_t                       req,
  output logic                                        pt_valid,
  output logic [2:0][amt_pkg::COORD_W-1:0]            pt,
  output amt_pkg::meta_t                              pt_meta
);

  amt_pkg::box_in_t box;
  logic [2:0]       cnt;
  logic             run;
  logic             bad;
  logic             accept;

  assign busy   = run && (cnt != 3'(amt_pkg::CORNERS - 1));
  assign accept = start && !busy;

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
    end else if (accept) begin
      run <= 1'b1;
      cnt <= '0;
    end else if (run) begin
      cnt <= cnt + 3'd1;
      if (cnt == 3'(amt_pkg::CORNERS - 1)) begin
        run <= 1'b0;
      end
    end
  end

  // Request payload
  always_ff @(posedge clk) begin
    if (accept) begin
      box <= req;
      bad <= (req.in_min_x > req.in_max_x) || (req.in_min_y > req.in_max_y) ||
             (req.in_min_z > req.in_max_z);
    end
  end

  // Corner select: bit 0 picks x, bit 1 y, bit 2 z from the maximum
  always_comb begin
    pt[0]         = cnt[0] ? box.in_max_x : box.in_min_x;
    pt[1]         = cnt[1] ? box.in_max_y : box.in_min_y;
    pt[2]         = cnt[2] ? box.in_max_z : box.in_min_z;
    pt_valid      = run;
    pt_meta.first = (cnt == 3'd0);
    pt_meta.last  = (cnt == 3'(amt_pkg::CORNERS - 1));
    pt_meta.bad   = bad;
    pt_meta.ws    = 1'b0;
    pt_meta.wzero = 1'b0;
  end

endmodule

`default_nettype wire

[src/amt_dot.sv]
// Dot-product pipeline: products, column sums, sign/magnitude split.
// Depends on amt_pkg.
`default_nettype none

module amt_dot #(
  parameter int FRAC_BITS = amt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire amt_pkg::matrix_t                      m,
  input  wire logic                                  pt_valid,
  input  wire logic [2:0][amt_pkg::COORD_W-1:0]      pt,
  input  wire amt_pkg::meta_t                        pt_meta,
  output logic                                       mag_valid,
  output logic [2:0][amt_pkg::MAG_W-1:0]             nm,
  output logic [amt_pkg::MAG_W-1:0]                  wm,
  output amt_pkg::lane_t [2:0]                       lane,
  output amt_pkg::meta_t                             mag_meta
);

  logic signed [amt_pkg::PROD_W-1:0]  prod [4][3];
  logic signed [amt_pkg::COORD_W-1:0] tr   [4];
  logic                               p_valid;
  amt_pkg::meta_t                     p_meta;

  logic signed [amt_pkg::SUM_W-1:0]   sum  [4];
  logic                               s_valid;
  amt_pkg::meta_t                     s_meta;

  // Stage 1: twelve products, translation row held alongside
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 3; r++) begin
        prod[c][r] <= $signed(pt[r]) * $signed(m[r][c]);
      end
      tr[c] <= $signed(m[3][c]);
    end
    p_meta <= pt_meta;
  end

  // Stage 2: column sums, translation scaled by one
  always_ff @(posedge clk) begin
    for (int c = 0; c < 4; c++) begin
      sum[c] <= amt_pkg::SUM_W'(prod[c][0]) + amt_pkg::SUM_W'(prod[c][1]) +
                amt_pkg::SUM_W'(prod[c][2]) + (amt_pkg::SUM_W'(tr[c]) <<< FRAC_BITS);
    end
    s_meta <= p_meta;
  end

  // Stage 3: sign and magnitude
  always_ff @(posedge clk) begin
    logic signed [amt_pkg::SUM_W-1:0] neg_w;
    logic signed [amt_pkg::SUM_W-1:0] neg_n;
    amt_pkg::meta_t                   meta_w;
    neg_w        = -sum[3];
    meta_w       = s_meta;
    meta_w.ws    = sum[3][amt_pkg::SUM_W-1];
    meta_w.wzero = (sum[3] == '0);
    wm    <= sum[3][amt_pkg::SUM_W-1] ? neg_w[amt_pkg::MAG_W-1:0]
                                      : sum[3][amt_pkg::MAG_W-1:0];
    for (int a = 0; a < 3; a++) begin
      neg_n = -sum[a];
      nm[a] <= sum[a][amt_pkg::SUM_W-1] ? neg_n[amt_pkg::MAG_W-1:0]
                                        : sum[a][amt_pkg::MAG_W-1:0];
      lane[a].ns    <= sum[a][amt_pkg::SUM_W-1];
      lane[a].nzero <= (sum[a] == '0);
      lane[a].pre   <= 1'b0;
    end
    mag_meta <= meta_w;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      s_valid   <= 1'b0;
      mag_valid <= 1'b0;
    end else begin
      p_valid   <= pt_valid;
      s_valid   <= p_valid;
      mag_valid <= s_valid;
    end
  end

endmodule

`default_nettype wire

[src/amt_div.sv]
// Restoring divider pipeline, one quotient bit per stage, three lanes
// sharing one divisor. Depends on amt_pkg.
`default_nettype none

module amt_div #(
  parameter int FRAC_BITS = amt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  input  wire logic [2:0][amt_pkg::MAG_W-1:0]        nm,
  input  wire logic [amt_pkg::MAG_W-1:0]             wm,
  input  wire amt_pkg::lane_t [2:0]                  in_lane,
  input  wire amt_pkg::meta_t                        in_meta,
  output logic                                       q_valid,
  output logic [2:0][amt_pkg::QUO_W-1:0]             q,
  output amt_pkg::lane_t [2:0]                       q_lane,
  output amt_pkg::meta_t                             q_meta
);

  localparam int SHIFT  = amt_pkg::QUO_W - FRAC_BITS;
  localparam int STAGES = amt_pkg::QUO_W + 1;

  logic [amt_pkg::MAG_W-1:0] rem_r  [STAGES][3];
  logic [amt_pkg::QUO_W-1:0] low_r  [STAGES][3];
  logic [amt_pkg::QUO_W-1:0] quo_r  [STAGES][3];
  amt_pkg::lane_t            lane_r [STAGES][3];
  logic [amt_pkg::MAG_W-1:0] wm_r   [STAGES];
  amt_pkg::meta_t            meta_r [STAGES];
  logic [STAGES-1:0]         vld_r;

  // Setup: top of the scaled dividend, and quotient range check
  always_ff @(posedge clk) begin
    amt_pkg::lane_t ln;
    for (int a = 0; a < 3; a++) begin
      ln     = in_lane[a];
      ln.pre = (nm[a] >> SHIFT) >= wm;
      rem_r[0][a]  <= nm[a] >> SHIFT;
      low_r[0][a]  <= {nm[a][SHIFT-1:0], FRAC_BITS'(0)};
      quo_r[0][a]  <= '0;
      lane_r[0][a] <= ln;
    end
    wm_r[0]   <= wm;
    meta_r[0] <= in_meta;
  end

  // One quotient bit per stage
  for (genvar i = 0; i < amt_pkg::QUO_W; i++) begin : g_step
    for (genvar a = 0; a < 3; a++) begin : g_lane
      logic [amt_pkg::MAG_W:0] t;
      logic [amt_pkg::MAG_W:0] diff;
      logic                    ge;

      always_comb begin
        t    = {rem_r[i][a], low_r[i][a][amt_pkg::QUO_W-1]};
        diff = t - {1'b0, wm_r[i]};
        ge   = (t >= {1'b0, wm_r[i]});
      end

      always_ff @(posedge clk) begin
        rem_r[i+1][a]  <= ge ? diff[amt_pkg::MAG_W-1:0] : t[amt_pkg::MAG_W-1:0];
        low_r[i+1][a]  <= {low_r[i][a][amt_pkg::QUO_W-2:0], 1'b0};
        quo_r[i+1][a]  <= {quo_r[i][a][amt_pkg::QUO_W-2:0], ge};
        lane_r[i+1][a] <= lane_r[i][a];
      end
    end

    always_ff @(posedge clk) begin
      wm_r[i+1]   <= wm_r[i];
      meta_r[i+1] <= meta_r[i];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  always_comb begin
    q_valid = vld_r[STAGES-1];
    q_meta  = meta_r[STAGES-1];
    for (int a = 0; a < 3; a++) begin
      q[a]      = quo_r[STAGES-1][a];
      q_lane[a] = lane_r[STAGES-1][a];
    end
  end

endmodule

`default_nettype wire

[src/amt_hull.sv]
// Saturation of projected coordinates and the min/max hull over corners.
// Depends on amt_pkg.
`default_nettype none

module amt_hull (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  q_valid,
  input  wire logic [2:0][amt_pkg::QUO_W-1:0]        q,
  input  wire amt_pkg::lane_t [2:0]                  q_lane,
  input  wire amt_pkg::meta_t                        q_meta,
  output logic                                       done,
  output amt_pkg::box_out_t                          res
);

  logic signed [amt_pkg::COORD_W-1:0] v      [3];
  logic                               v_ovf;
  logic                               v_valid;
  amt_pkg::meta_t                     v_meta;

  logic signed [amt_pkg::COORD_W-1:0] acc_min [3];
  logic signed [amt_pkg::COORD_W-1:0] acc_max [3];
  logic                               acc_ovf;
  logic signed [amt_pkg::COORD_W-1:0] min_next [3];
  logic signed [amt_pkg::COORD_W-1:0] max_next [3];
  logic                               ovf_next;

  // Sign, zero divisor and range saturation per axis
  always_ff @(posedge clk) begin
    logic                        neg;
    logic [amt_pkg::QUO_W-1:0]   lim;
    logic [2:0]                  o;
    for (int a = 0; a < 3; a++) begin
      neg  = (q_lane[a].ns != q_meta.ws) && !q_lane[a].nzero;
      lim  = neg ? amt_pkg::NEG_LIM : amt_pkg::POS_LIM;
      o[a] = 1'b1;
      if (q_meta.wzero) begin
        v[a] <= q_lane[a].nzero ? '0 :
                (q_lane[a].ns ? amt_pkg::NEG_LIM : amt_pkg::POS_LIM);
      end else if (q_lane[a].pre || (q[a] > lim)) begin
        v[a] <= lim;
      end else begin
        v[a] <= neg ? -q[a] : q[a];
        o[a] = 1'b0;
      end
    end
    v_ovf  <= |o;
    v_meta <= q_meta;
  end

  // Running hull; the first corner of a box restarts it
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      min_next[a] = (v_meta.first || v[a] < acc_min[a]) ? v[a] : acc_min[a];
      max_next[a] = (v_meta.first || v[a] > acc_max[a]) ? v[a] : acc_max[a];
    end
    ovf_next = v_ovf || (!v_meta.first && acc_ovf);
  end

  always_ff @(posedge clk) begin
    if (v_valid) begin
      acc_min <= min_next;
      acc_max <= max_next;
      acc_ovf <= ovf_next;
      if (v_meta.last) begin
        if (v_meta.bad) begin
          res.out_min_x <= amt_pkg::POS_LIM;
          res.out_min_y <= amt_pkg::POS_LIM;
          res.out_min_z <= amt_pkg::POS_LIM;
          res.out_max_x <= amt_pkg::NEG_LIM;
          res.out_max_y <= amt_pkg::NEG_LIM;
          res.out_max_z <= amt_pkg::NEG_LIM;
          res.box_valid <= 1'b0;
          res.overflow  <= 1'b0;
        end else begin
          res.out_min_x <= min_next[0];
          res.out_min_y <= min_next[1];
          res.out_min_z <= min_next[2];
          res.out_max_x <= max_next[0];
          res.out_max_y <= max_next[1];
          res.out_max_z <= max_next[2];
          res.box_valid <= 1'b1;
          res.overflow  <= ovf_next;
        end
      end
    end
  end

  // Valid and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      v_valid <= 1'b0;
      done    <= 1'b0;
    end else begin
      v_valid <= q_valid;
      done    <= v_valid && v_meta.last;
    end
  end

endmodule

`default_nettype wire

[src/aabb_matrix_transform.sv]
// Top level: transforms an axis-aligned box by a 4x4 matrix and returns
// the hull of its eight projected corners. Depends on amt_pkg and modules.
//
// Usage:
//   Request: drive req and raise start; it is taken at an edge where busy
//   is low. Each box issues one corner per cycle through the single shared
//   corner datapath (12 multipliers, one three-lane divider); a new request
//   is taken, at the earliest, as the previous box issues its last corner.
//   Result: done is high for one cycle with res valid once the last corner
//   has passed 3 dot-product stages, 33 divider stages (setup, then one
//   quotient bit per stage), saturation and hull. The receiver cannot
//   stall; results leave in request order.
//   Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready
//   is always high, indexes above seven are dropped. Write only when idle.
//   Reset: synchronous rst empties the pipeline and loads the identity matrix.
//   An inverted box (min above max on any axis) yields the empty box with
//   box_valid and overflow low.
`default_nettype none

module aabb_matrix_transform #(
  parameter int FRAC_BITS = amt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire amt_pkg::box_in_t                   req,
  output logic                                    done,
  output amt_pkg::box_out_t                       res,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [amt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [amt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [amt_pkg::CFG_DATA_W-1:0]         regs [amt_pkg::NUM_REGS];
  amt_pkg::matrix_t                       m;

  logic                                   pt_valid;
  logic [2:0][amt_pkg::COORD_W-1:0]       pt;
  amt_pkg::meta_t                         pt_meta;

  logic                                   mag_valid;
  logic [2:0][amt_pkg::MAG_W-1:0]         nm;
  logic [amt_pkg::MAG_W-1:0]              wm;
  amt_pkg::lane_t [2:0]                   mag_lane;
  amt_pkg::meta_t                         mag_meta;

  logic                                   q_valid;
  logic [2:0][amt_pkg::QUO_W-1:0]         q;
  amt_pkg::lane_t [2:0]                   q_lane;
  amt_pkg::meta_t                         q_meta;

  assign cfg_ready = 1'b1;

  // Matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < amt_pkg::NUM_REGS; i++) begin
        regs[i] <= amt_pkg::reg_reset(amt_pkg::CFG_IDX_W'(i));
      end
    end else if (cfg_valid && cfg_ready &&
                 (cfg_index < amt_pkg::CFG_IDX_W'(amt_pkg::NUM_REGS))) begin
      regs[cfg_index[2:0]] <= cfg_data;
    end
  end

  // Entry (r,c) sits in register 2r + c/2, low half for even c
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = regs[r*2 + c/2][(c%2)*amt_pkg::COORD_W +: amt_pkg::COORD_W];
      end
    end
  end

  amt_corner u_corner (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .pt_valid (pt_valid),
    .pt       (pt),
    .pt_meta  (pt_meta)
  );

  amt_dot #(.FRAC_BITS(FRAC_BITS)) u_dot (
    .clk       (clk),
    .rst       (rst),
    .m         (m),
    .pt_valid  (pt_valid),
    .pt        (pt),
    .pt_meta   (pt_meta),
    .mag_valid (mag_valid),
    .nm        (nm),
    .wm        (wm),
    .lane      (mag_lane),
    .mag_meta  (mag_meta)
  );

  amt_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mag_valid),
    .nm       (nm),
    .wm       (wm),
    .in_lane  (mag_lane),
    .in_meta  (mag_meta),
    .q_valid  (q_valid),
    .q        (q),
    .q_lane   (q_lane),
    .q_meta   (q_meta)
  );

  amt_hull u_hull (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q       (q),
    .q_lane  (q_lane),
    .q_meta  (q_meta),
    .done    (done),
    .res     (res)
  );

`include "aabb_matrix_transform_macros.svh"

  `AMT_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy)
  `AMT_ASSERT_IMP(a_empty_no_ovf, clk, rst, done && !res.box_valid, !res.overflow)
  `AMT_ASSERT_NXT(a_done_spaced, clk, rst, done, !done)

endmodule

`default_nettype wire

[test/aabb_matrix_transform_tb.sv]
// Testbench for aabb_matrix_transform: drives boxes and matrix loads and checks
// each hull against an in-bench exact fixed-point predictor. Depends on amt_pkg.
`timescale 1ns / 100ps
`default_nettype none

module aabb_matrix_transform_tb;

  localparam int FB         = amt_pkg::FRAC_BITS_DEF;
  localparam int CYCLE_MAX  = 400000;
  localparam int RAND_ITEMS = 1030;
  localparam int CALM_ITEMS = 150;
  localparam logic [31:0] FIX_ONE = 32'h0001_0000;

  logic clk, rst, start, busy, done, cfg_valid, cfg_ready;
  amt_pkg::box_in_t req;
  amt_pkg::box_out_t res;
  logic [amt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [amt_pkg::CFG_DATA_W-1:0] cfg_data;

  // Predictor copy of the matrix registers
  logic [amt_pkg::CFG_DATA_W-1:0] mat_regs [amt_pkg::NUM_REGS];
  // Expected hulls in request order
  amt_pkg::box_out_t hull_fifo [64];
  logic [5:0] hull_head = '0, hull_tail = '0;
  int errors = 0, cycles = 0, boxes_sent = 0, hulls_seen = 0, cfg_writes = 0;
  bit calm = 0;

  aabb_matrix_transform u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .res(res), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_MAX) begin
      $display("aabb_matrix_transform_tb: done, errors");
      $finish;
    end
  end

  function automatic logic signed [127:0] entry(int r, int c);
    logic [63:0] rv;
    logic signed [31:0] h;
    rv = mat_regs[3'(r * 2 + c / 2)];
    h  = (c % 2) ? rv[63:32] : rv[31:0];
    return h;
  endfunction

  // Exact column dot product of (x,y,z,1)
  function automatic logic signed [127:0] dot_col(logic signed [127:0] p0,
      logic signed [127:0] p1, logic signed [127:0] p2, int c);
    return p0 * entry(0, c) + p1 * entry(1, c) + p2 * entry(2, c) +
           (entry(3, c) <<< FB);
  endfunction

  // n / w scaled by 2^FB, truncated toward zero and saturated
  function automatic logic signed [127:0] divide_sat(logic signed [127:0] n,
      logic signed [127:0] w, inout logic ovf);
    logic signed [127:0] nm, wm, q, lim;
    logic neg;
    if (w == 0) begin
      ovf = 1'b1;
      if (n == 0) return 0;
      return (n < 0) ? -128'sd2147483648 : 128'sd2147483647;
    end
    nm  = (n < 0) ? -n : n;
    wm  = (w < 0) ? -w : w;
    neg = ((n < 0) != (w < 0)) && (n != 0);
    lim = neg ? 128'sd2147483648 : 128'sd2147483647;
    q   = (nm <<< FB) / wm;
    if (q > lim) begin
      ovf = 1'b1;
      q = lim;
    end
    return neg ? -q : q;
  endfunction

  function automatic amt_pkg::box_out_t predict_hull(amt_pkg::box_in_t b);
    amt_pkg::box_out_t o;
    logic signed [127:0] lo [3], hi [3], mn [3], mx [3], w, v, px, py, pz;
    logic ovf;
    lo[0] = b.in_min_x; lo[1] = b.in_min_y; lo[2] = b.in_min_z;
    hi[0] = b.in_max_x; hi[1] = b.in_max_y; hi[2] = b.in_max_z;
    if (lo[0] > hi[0] || lo[1] > hi[1] || lo[2] > hi[2]) begin
      o = '0;
      o.out_min_x = amt_pkg::POS_LIM; o.out_min_y = amt_pkg::POS_LIM;
      o.out_min_z = amt_pkg::POS_LIM;
      o.out_max_x = amt_pkg::NEG_LIM; o.out_max_y = amt_pkg::NEG_LIM;
      o.out_max_z = amt_pkg::NEG_LIM;
      return o;
    end
    ovf = 1'b0;
    for (int a = 0; a < 3; a++) begin
      mn[a] = 128'sd2147483647;
      mx[a] = -128'sd2147483648;
    end
    for (int k = 0; k < 8; k++) begin
      px = (k & 1) ? hi[0] : lo[0];
      py = (k & 2) ? hi[1] : lo[1];
      pz = (k & 4) ? hi[2] : lo[2];
      w  = dot_col(px, py, pz, 3);
      for (int a = 0; a < 3; a++) begin
        v = divide_sat(dot_col(px, py, pz, a), w, ovf);
        if (v < mn[a]) mn[a] = v;
        if (v > mx[a]) mx[a] = v;
      end
    end
    o.out_min_x = mn[0][31:0]; o.out_min_y = mn[1][31:0]; o.out_min_z = mn[2][31:0];
    o.out_max_x = mx[0][31:0]; o.out_max_y = mx[1][31:0]; o.out_max_z = mx[2][31:0];
    o.box_valid = 1'b1;
    o.overflow  = ovf;
    return o;
  endfunction

  function automatic bit hulls_pending();
    return hull_head != hull_tail;
  endfunction

  // Request side: start stays high across back-to-back requests
  task automatic send_box(amt_pkg::box_in_t b);
    req   <= b;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    hull_fifo[hull_tail] = predict_hull(b);
    hull_tail = hull_tail + 6'd1;
    boxes_sent++;
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (!calm && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 18));
  endtask

  task automatic wait_idle();
    idle_cycles(1);
    while (hulls_pending()) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic cfg_write(logic [amt_pkg::CFG_IDX_W-1:0] idx,
      logic [amt_pkg::CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    if (idx < amt_pkg::NUM_REGS) mat_regs[idx[2:0]] = d;
    cfg_writes++;
  endtask

  task automatic cfg_close();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Loads a full matrix given as m[row][col]
  task automatic load_matrix(logic [31:0] m [4][4]);
    wait_idle();
    for (int r = 0; r < 4; r++) begin
      cfg_write(amt_pkg::CFG_IDX_W'(r * 2),     {m[r][1], m[r][0]});
      cfg_write(amt_pkg::CFG_IDX_W'(r * 2 + 1), {m[r][3], m[r][2]});
    end
    cfg_close();
  endtask

  function automatic amt_pkg::box_in_t mk_box(logic [31:0] x0, logic [31:0] y0,
      logic [31:0] z0, logic [31:0] x1, logic [31:0] y1, logic [31:0] z1);
    amt_pkg::box_in_t b;
    b.in_min_x = x0; b.in_min_y = y0; b.in_min_z = z0;
    b.in_max_x = x1; b.in_max_y = y1; b.in_max_z = z1;
    return b;
  endfunction

  // Fixed value: mostly modest magnitudes, sometimes full range
  function automatic logic [31:0] rand_fix(int spread);
    logic [31:0] v;
    logic signed [31:0] s;
    v = $urandom;
    case ($urandom_range(0, 3))
      0:       return v;
      1:       return 32'($signed(v[19:0]));
      default: begin
        if (spread <= 0) return v;
        // sign-extend the low spread bits
        s = $signed(v << (32 - spread));
        s = s >>> (32 - spread);
        return s;
      end
    endcase
  endfunction

  function automatic amt_pkg::box_in_t rand_box();
    logic [31:0] a [3], b [3];
    int spread;
    spread = $urandom_range(0, 1) ? 26 : 22;
    for (int i = 0; i < 3; i++) begin
      a[i] = rand_fix(spread);
      b[i] = rand_fix(spread);
      // mostly well-formed boxes; some inverted ones
      if ($urandom_range(0, 15) != 0 && $signed(a[i]) > $signed(b[i])) begin
        a[i] ^= b[i]; b[i] ^= a[i]; a[i] ^= b[i];
      end
    end
    return mk_box(a[0], a[1], a[2], b[0], b[1], b[2]);
  endfunction

  task automatic identity_matrix(output logic [31:0] m [4][4]);
    for (int r = 0; r < 4; r++)
      for (int c = 0; c < 4; c++) m[r][c] = (r == c) ? FIX_ONE : 32'h0;
  endtask

  task automatic check_field(string name, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch: expected %h actual %h", $time, name, e, a);
      errors++;
    end
  endtask

  // Result checker
  always @(posedge clk) begin
    amt_pkg::box_out_t e;
    if (!rst && done) begin
      hulls_seen++;
      if (!hulls_pending()) begin
        $display("%0t: unexpected result %h", $time, res);
        errors++;
      end else begin
        e = hull_fifo[hull_head];
        hull_head = hull_head + 6'd1;
        check_field("out_min_x", e.out_min_x, res.out_min_x);
        check_field("out_min_y", e.out_min_y, res.out_min_y);
        check_field("out_min_z", e.out_min_z, res.out_min_z);
        check_field("out_max_x", e.out_max_x, res.out_max_x);
        check_field("out_max_y", e.out_max_y, res.out_max_y);
        check_field("out_max_z", e.out_max_z, res.out_max_z);
        check_field("box_valid", e.box_valid, res.box_valid);
        check_field("overflow",  e.overflow,  res.overflow);
      end
    end
  end

  // Reset identity: extremes of the fields, inverted boxes, degenerate boxes
  task automatic test_reset_identity();
    send_box(mk_box(0, 0, 0, 0, 0, 0));
    send_box(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    maybe_gap();
    send_box(mk_box(32'hFFFF_0000, 32'h0, 32'h0001_8000, FIX_ONE, FIX_ONE, 32'h0002_0000));
    send_box(mk_box(FIX_ONE, 0, 0, 0, FIX_ONE, FIX_ONE));
    send_box(mk_box(0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0));
    send_box(mk_box(0, 0, 1, 0, 0, 0));
    send_box(mk_box(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
  endtask

  // Zero W everywhere: saturation by numerator sign, zero numerator gives zero
  task automatic test_zero_w();
    logic [31:0] m [4][4];
    identity_matrix(m);
    m[3][3] = 0;
    load_matrix(m);
    send_box(mk_box(32'hFFFF_0000, 32'hFFFF_0000, 0, FIX_ONE, 0, FIX_ONE));
    send_box(mk_box(0, 0, 0, 0, 0, 0));
    send_box(mk_box(5, 5, 5, 9, 9, 9));
  endtask

  // Perspective (W = z), large scale overflow, all-ones, all-zero and all-8000_0000 matrices
  task automatic test_special_matrices();
    logic [31:0] m [4][4];
    identity_matrix(m);
    m[2][3] = FIX_ONE; m[3][3] = 0;
    load_matrix(m);
    send_box(mk_box(32'hFFFE_0000, 32'hFFFE_0000, FIX_ONE, 32'h0002_0000, 32'h0002_0000,
                    32'h0004_0000));
    send_box(mk_box(32'h7000_0000, 0, 1, 32'h7FFF_FFFF, FIX_ONE, 2));
    send_box(mk_box(0, 0, 32'hFFFF_0000, FIX_ONE, FIX_ONE, FIX_ONE));
    identity_matrix(m);
    m[0][0] = 32'h7FFF_FFFF; m[1][1] = 32'h8000_0000; m[3][2] = 32'h7FFF_FFFF;
    load_matrix(m);
    send_box(mk_box(FIX_ONE, FIX_ONE, 0, 32'h0004_0000, 32'h0004_0000, 0));
    send_box(mk_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
    for (int r = 0; r < 4; r++) for (int c = 0; c < 4; c++) m[r][c] = 32'hFFFF_FFFF;
    load_matrix(m);
    send_box(mk_box(32'h8000_0000, 0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, FIX_ONE, 0));
    send_box(mk_box(0, 0, 0, 0, 0, 0));
    for (int r = 0; r < 4; r++) for (int c = 0; c < 4; c++) m[r][c] = 32'h0;
    load_matrix(m);
    send_box(mk_box(32'hFFFF_0000, 0, 0, FIX_ONE, 0, 0));
    for (int r = 0; r < 4; r++) for (int c = 0; c < 4; c++) m[r][c] = 32'h8000_0000;
    load_matrix(m);
    send_box(mk_box(FIX_ONE, FIX_ONE, FIX_ONE, 32'h0002_0000, FIX_ONE, FIX_ONE));
  endtask

  // Writes to indexes above seven must leave the matrix alone
  task automatic test_reserved_index();
    logic [31:0] m [4][4];
    identity_matrix(m);
    load_matrix(m);
    wait_idle();
    for (int i = amt_pkg::NUM_REGS; i < 16; i++)
      cfg_write(amt_pkg::CFG_IDX_W'(i), {$urandom, $urandom});
    cfg_close();
    send_box(mk_box(32'hFFFF_0000, 32'h0, 32'h0001_8000, FIX_ONE, FIX_ONE, 32'h0002_0000));
  endtask

  // Random boxes over a series of random matrices; the last part has no gaps
  task automatic test_random_boxes();
    logic [31:0] m [4][4];
    int spread;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0 && i < RAND_ITEMS - CALM_ITEMS) begin
        spread = $urandom_range(0, 2) ? 18 : 32;
        for (int r = 0; r < 4; r++)
          for (int c = 0; c < 4; c++) m[r][c] = rand_fix(spread);
        if ($urandom_range(0, 1)) begin
          // affine: W fixed at one
          m[0][3] = 0; m[1][3] = 0; m[2][3] = 0; m[3][3] = FIX_ONE;
        end
        load_matrix(m);
      end
      if (i >= RAND_ITEMS - CALM_ITEMS) calm = 1;
      send_box(rand_box());
      maybe_gap();
    end
  endtask

  initial begin
    for (int i = 0; i < amt_pkg::NUM_REGS; i++)
      mat_regs[i] = amt_pkg::reg_reset(amt_pkg::CFG_IDX_W'(i));
    rst = 1'b1; start = 1'b0; req = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_identity();
    test_zero_w();
    test_special_matrices();
    test_reserved_index();
    test_random_boxes();
    idle_cycles(1);
    while (hulls_pending()) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d boxes, checked %0d hulls, %0d register writes (incl. reserved).",
             boxes_sent, hulls_seen, cfg_writes);
    $display("Covered identity, zero W, perspective, saturation and random matrices.");
    if (errors == 0) begin
      $display("aabb_matrix_transform_tb: done, clean");
    end else begin
      $display("aabb_matrix_transform_tb: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/amt_pkg.sv
src/amt_corner.sv
src/amt_dot.sv
src/amt_div.sv
src/amt_hull.sv
src/aabb_matrix_transform.sv
test/aabb_matrix_transform_tb.sv
